// ===== rtl/core/slx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slx_pkg
// Shared types and constants for the script lexer: transaction payloads,
// token kinds, error codes, scan modes, byte codes and the keyword table.
// ----------------------------------------------------------------------------
package slx_pkg;

	// Input transaction: one source byte
	typedef struct packed {
		logic [7:0] source_byte;
		logic       end_of_source;
	} slx_in_t;

	// Output transaction: one token or error
	typedef struct packed {
		logic [5:0]  token_kind;
		logic [1:0]  error_code;
		logic [15:0] start_line;
		logic [15:0] start_column;
		logic [15:0] lexeme_length;
		logic        last_of_run;
	} slx_out_t;

	// Results of one scanned byte, handed from scanner to result queue
	typedef struct packed {
		logic [1:0] count;
		slx_out_t   r0;
		slx_out_t   r1;
	} slx_res_t;

	// Result queue geometry
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;

	// Scan modes
	localparam logic [2:0] M_IDLE    = 3'd0;
	localparam logic [2:0] M_OP      = 3'd1;
	localparam logic [2:0] M_SLASH   = 3'd2;
	localparam logic [2:0] M_COMMENT = 3'd3;
	localparam logic [2:0] M_STRING  = 3'd4;
	localparam logic [2:0] M_INT     = 3'd5;
	localparam logic [2:0] M_FRAC    = 3'd6;
	localparam logic [2:0] M_IDENT   = 3'd7;

	// Pending operator codes
	localparam logic [1:0] OP_BANG    = 2'd0;
	localparam logic [1:0] OP_EQUAL   = 2'd1;
	localparam logic [1:0] OP_GREATER = 2'd2;
	localparam logic [1:0] OP_LESS    = 2'd3;

	// Token kinds
	localparam logic [5:0] KIND_LEFT_PAREN  = 6'd0;
	localparam logic [5:0] KIND_RIGHT_PAREN = 6'd1;
	localparam logic [5:0] KIND_LEFT_BRACE  = 6'd2;
	localparam logic [5:0] KIND_RIGHT_BRACE = 6'd3;
	localparam logic [5:0] KIND_COMMA       = 6'd4;
	localparam logic [5:0] KIND_DOT         = 6'd5;
	localparam logic [5:0] KIND_MINUS       = 6'd6;
	localparam logic [5:0] KIND_PLUS        = 6'd7;
	localparam logic [5:0] KIND_SEMICOLON   = 6'd8;
	localparam logic [5:0] KIND_SLASH       = 6'd9;
	localparam logic [5:0] KIND_STAR        = 6'd10;
	localparam logic [5:0] KIND_BANG        = 6'd11;
	localparam logic [5:0] KIND_BANG_EQ     = 6'd12;
	localparam logic [5:0] KIND_COMMENT     = 6'd19;
	localparam logic [5:0] KIND_IDENTIFIER  = 6'd20;
	localparam logic [5:0] KIND_STRING      = 6'd21;
	localparam logic [5:0] KIND_NUMBER      = 6'd22;
	localparam logic [5:0] KIND_CHAR        = 6'd23;
	localparam logic [5:0] KIND_AND         = 6'd24;
	localparam logic [5:0] KIND_NIL         = 6'd39;

	// Error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_UNTERM  = 2'd1;
	localparam logic [1:0] ERR_BADCHAR = 2'd2;

	// Byte codes
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LESS   = 8'h3C;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_GREAT  = 8'h3E;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Keyword text, first byte in the low byte, zero padded
	localparam logic [55:0] KW_TEXT [16] = '{
		56'h646e61,       // and
		56'h726f,         // or
		56'h7373616c63,   // class
		56'h6669,         // if
		56'h65736c65,     // else
		56'h726176,       // var
		56'h636e7566,     // func
		56'h726f66,       // for
		56'h656c696877,   // while
		56'h6e7275746572, // return
		56'h746e697270,   // print
		56'h7265707573,   // super
		56'h73696874,     // this
		56'h65757274,     // true
		56'h65736c6166,   // false
		56'h6c696e        // nil
	};

	localparam logic [2:0] KW_LEN [16] = '{
		3'd3, 3'd2, 3'd5, 3'd2, 3'd4, 3'd3, 3'd4, 3'd3,
		3'd5, 3'd6, 3'd5, 3'd5, 3'd4, 3'd4, 3'd5, 3'd3
	};

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
	endfunction

	// Identifier kind: keyword kinds follow KIND_AND in table order
	function automatic logic [5:0] ident_kind(input logic [55:0] win,
	                                          input logic short_len,
	                                          input logic [2:0] len3);
		logic [5:0] k;
		k = KIND_IDENTIFIER;
		for (int i = 15; i >= 0; i--) begin
			if (short_len && (len3 == KW_LEN[i]) && (win == KW_TEXT[i]))
				k = KIND_AND + 6'(i);
		end
		return k;
	endfunction

endpackage

// ===== rtl/core/slx_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slx_scan
// Scanner state and per-byte next-state logic; produces up to two results
// for the registered byte in a single pass.
// ----------------------------------------------------------------------------
module slx_scan #(
	parameter int CB = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  slx_pkg::slx_in_t item,
	output slx_pkg::slx_res_t res
);

	logic [2:0]    mode_q;
	logic [1:0]    op_q;
	logic [CB-1:0] tline_q, tcol_q, tlen_q;
	logic [55:0]   kw_q;
	logic [CB-1:0] line_q, col_q;

	logic [2:0]    mode_d;
	logic [1:0]    op_d;
	logic [CB-1:0] tline_d, tcol_d, tlen_d;
	logic [55:0]   kw_d;
	logic [CB-1:0] line_d, col_d;

	function automatic logic [CB-1:0] inc_sat(input logic [CB-1:0] v);
		return (v == {CB{1'b1}}) ? v : v + CB'(1);
	endfunction

	function automatic logic [15:0] out16(input logic [CB-1:0] v);
		logic [CB+15:0] w;
		w = {16'b0, v};
		if (w > (CB+16)'(16'hFFFF))
			return 16'hFFFF;
		return w[15:0];
	endfunction

	function automatic slx_pkg::slx_out_t make_tok(input logic [5:0] kind,
	                                               input logic [1:0] err,
	                                               input logic [CB-1:0] l,
	                                               input logic [CB-1:0] c,
	                                               input logic [CB-1:0] len);
		slx_pkg::slx_out_t t;
		t.token_kind    = kind;
		t.error_code    = err;
		t.start_line    = out16(l);
		t.start_column  = out16(c);
		t.lexeme_length = out16(len);
		t.last_of_run   = 1'b0;
		return t;
	endfunction

	// Next state and results for the byte in the input register
	always_comb begin
		logic [7:0]        b;
		logic              last;
		logic [CB-1:0]     col;
		logic              do_fresh;
		logic [1:0]        n;
		logic [5:0]        fk;
		logic              femit;
		logic [1:0]        ferr;
		slx_pkg::slx_out_t slot [2];

		b        = item.source_byte;
		last     = item.end_of_source;
		col      = inc_sat(col_q);
		do_fresh = 1'b0;
		n        = 2'd0;
		fk       = slx_pkg::KIND_LEFT_PAREN;
		femit    = 1'b0;
		ferr     = slx_pkg::ERR_NONE;
		slot[0]  = '0;
		slot[1]  = '0;
		mode_d   = mode_q;
		op_d     = op_q;
		tline_d  = tline_q;
		tcol_d   = tcol_q;
		tlen_d   = tlen_q;
		kw_d     = kw_q;

		// token in progress
		unique case (mode_q)
			slx_pkg::M_OP: begin
				if (b == slx_pkg::CH_EQUAL) begin
					slot[0] = make_tok(slx_pkg::KIND_BANG_EQ + {3'b0, op_q, 1'b0},
						slx_pkg::ERR_NONE, tline_q, tcol_q, CB'(2));
					n       = 2'd1;
					mode_d  = slx_pkg::M_IDLE;
				end else begin
					slot[0]  = make_tok(slx_pkg::KIND_BANG + {3'b0, op_q, 1'b0},
						slx_pkg::ERR_NONE, tline_q, tcol_q, CB'(1));
					n        = 2'd1;
					do_fresh = 1'b1;
				end
			end
			slx_pkg::M_SLASH: begin
				if (b == slx_pkg::CH_SLASH) begin
					mode_d = slx_pkg::M_COMMENT;
					tlen_d = CB'(2);
				end else begin
					slot[0]  = make_tok(slx_pkg::KIND_SLASH, slx_pkg::ERR_NONE,
						tline_q, tcol_q, CB'(1));
					n        = 2'd1;
					do_fresh = 1'b1;
				end
			end
			slx_pkg::M_COMMENT: begin
				if (b == slx_pkg::CH_NL) begin
					slot[0] = make_tok(slx_pkg::KIND_COMMENT, slx_pkg::ERR_NONE,
						tline_q, tcol_q, tlen_q);
					n       = 2'd1;
					mode_d  = slx_pkg::M_IDLE;
				end else begin
					tlen_d = inc_sat(tlen_q);
				end
			end
			slx_pkg::M_STRING: begin
				tlen_d = inc_sat(tlen_q);
				if (b == slx_pkg::CH_QUOTE) begin
					slot[0] = make_tok(slx_pkg::KIND_STRING, slx_pkg::ERR_NONE,
						tline_q, tcol_q, tlen_d);
					n       = 2'd1;
					mode_d  = slx_pkg::M_IDLE;
				end
			end
			slx_pkg::M_INT: begin
				if (slx_pkg::is_digit(b) || (b == slx_pkg::CH_UNDER)) begin
					tlen_d = inc_sat(tlen_q);
				end else if (b == slx_pkg::CH_DOT) begin
					tlen_d = inc_sat(tlen_q);
					mode_d = slx_pkg::M_FRAC;
				end else begin
					slot[0]  = make_tok(slx_pkg::KIND_NUMBER, slx_pkg::ERR_NONE,
						tline_q, tcol_q, tlen_q);
					n        = 2'd1;
					do_fresh = 1'b1;
				end
			end
			slx_pkg::M_FRAC: begin
				if (slx_pkg::is_digit(b)) begin
					tlen_d = inc_sat(tlen_q);
				end else begin
					slot[0]  = make_tok(slx_pkg::KIND_NUMBER, slx_pkg::ERR_NONE,
						tline_q, tcol_q, tlen_q);
					n        = 2'd1;
					do_fresh = 1'b1;
				end
			end
			slx_pkg::M_IDENT: begin
				if (slx_pkg::is_alpha(b) || slx_pkg::is_digit(b)) begin
					// window keeps the first seven bytes
					if (tlen_q < CB'(7))
						kw_d[8*tlen_q[2:0] +: 8] = b;
					tlen_d = inc_sat(tlen_q);
				end else begin
					slot[0]  = make_tok(slx_pkg::ident_kind(kw_q, (tlen_q >> 3) == '0,
						tlen_q[2:0]), slx_pkg::ERR_NONE, tline_q, tcol_q, tlen_q);
					n        = 2'd1;
					do_fresh = 1'b1;
				end
			end
			default: begin
				do_fresh = 1'b1;
			end
		endcase

		// byte scanned with no token in progress (also the lookahead byte)
		if (do_fresh) begin
			femit  = 1'b1;
			fk     = slx_pkg::KIND_LEFT_PAREN;
			ferr   = slx_pkg::ERR_NONE;
			mode_d = slx_pkg::M_IDLE;
			case (b) inside
				slx_pkg::CH_LPAREN: fk = slx_pkg::KIND_LEFT_PAREN;
				slx_pkg::CH_RPAREN: fk = slx_pkg::KIND_RIGHT_PAREN;
				slx_pkg::CH_LBRACE: fk = slx_pkg::KIND_LEFT_BRACE;
				slx_pkg::CH_RBRACE: fk = slx_pkg::KIND_RIGHT_BRACE;
				slx_pkg::CH_COMMA:  fk = slx_pkg::KIND_COMMA;
				slx_pkg::CH_DOT:    fk = slx_pkg::KIND_DOT;
				slx_pkg::CH_MINUS:  fk = slx_pkg::KIND_MINUS;
				slx_pkg::CH_PLUS:   fk = slx_pkg::KIND_PLUS;
				slx_pkg::CH_SEMI:   fk = slx_pkg::KIND_SEMICOLON;
				slx_pkg::CH_STAR:   fk = slx_pkg::KIND_STAR;
				slx_pkg::CH_BANG, slx_pkg::CH_EQUAL, slx_pkg::CH_GREAT,
				slx_pkg::CH_LESS: begin
					femit  = 1'b0;
					mode_d = slx_pkg::M_OP;
					case (b)
						slx_pkg::CH_BANG:  op_d = slx_pkg::OP_BANG;
						slx_pkg::CH_EQUAL: op_d = slx_pkg::OP_EQUAL;
						slx_pkg::CH_GREAT: op_d = slx_pkg::OP_GREATER;
						default:           op_d = slx_pkg::OP_LESS;
					endcase
				end
				slx_pkg::CH_SLASH: begin
					femit  = 1'b0;
					mode_d = slx_pkg::M_SLASH;
				end
				slx_pkg::CH_QUOTE: begin
					femit  = 1'b0;
					mode_d = slx_pkg::M_STRING;
				end
				slx_pkg::CH_SP, slx_pkg::CH_CR, slx_pkg::CH_TAB, slx_pkg::CH_NL: begin
					femit = 1'b0;
				end
				default: begin
					if (slx_pkg::is_digit(b)) begin
						femit  = 1'b0;
						mode_d = slx_pkg::M_INT;
					end else if (slx_pkg::is_alpha(b)) begin
						femit  = 1'b0;
						mode_d = slx_pkg::M_IDENT;
						kw_d   = {48'b0, b};
					end else begin
						ferr = slx_pkg::ERR_BADCHAR;
					end
				end
			endcase
			// a new token starts here
			if (!femit && (mode_d != slx_pkg::M_IDLE)) begin
				tline_d = line_q;
				tcol_d  = col;
				tlen_d  = CB'(1);
			end
			if (femit) begin
				slot[n[0]] = make_tok(fk, ferr, line_q, col, CB'(1));
				n          = n + 2'd1;
			end
		end

		// line and column tracking
		if (b == slx_pkg::CH_NL) begin
			line_d = inc_sat(line_q);
			col_d  = '0;
		end else begin
			line_d = line_q;
			col_d  = col;
		end

		// end of source: flush what is pending, then back to reset state
		if (last) begin
			unique case (mode_d)
				slx_pkg::M_OP: begin
					slot[n[0]] = make_tok(slx_pkg::KIND_BANG + {3'b0, op_d, 1'b0},
						slx_pkg::ERR_NONE, tline_d, tcol_d, CB'(1));
					n          = n + 2'd1;
				end
				slx_pkg::M_SLASH: begin
					slot[n[0]] = make_tok(slx_pkg::KIND_SLASH, slx_pkg::ERR_NONE,
						tline_d, tcol_d, CB'(1));
					n          = n + 2'd1;
				end
				slx_pkg::M_COMMENT: begin
					slot[n[0]] = make_tok(slx_pkg::KIND_COMMENT, slx_pkg::ERR_NONE,
						tline_d, tcol_d, tlen_d);
					n          = n + 2'd1;
				end
				slx_pkg::M_STRING: begin
					slot[n[0]] = make_tok(slx_pkg::KIND_LEFT_PAREN, slx_pkg::ERR_UNTERM,
						tline_d, tcol_d, tlen_d);
					n          = n + 2'd1;
				end
				slx_pkg::M_INT, slx_pkg::M_FRAC: begin
					slot[n[0]] = make_tok(slx_pkg::KIND_NUMBER, slx_pkg::ERR_NONE,
						tline_d, tcol_d, tlen_d);
					n          = n + 2'd1;
				end
				slx_pkg::M_IDENT: begin
					slot[n[0]] = make_tok(slx_pkg::ident_kind(kw_d, (tlen_d >> 3) == '0,
						tlen_d[2:0]), slx_pkg::ERR_NONE, tline_d, tcol_d, tlen_d);
					n          = n + 2'd1;
				end
				default: begin
				end
			endcase
			mode_d  = slx_pkg::M_IDLE;
			op_d    = '0;
			tline_d = '0;
			tcol_d  = '0;
			tlen_d  = '0;
			kw_d    = '0;
			line_d  = '0;
			col_d   = '0;
		end

		// final result of this byte carries last_of_run
		slot[0].last_of_run = (n == 2'd1);
		slot[1].last_of_run = (n == 2'd2);
		res.count = n;
		res.r0    = slot[0];
		res.r1    = slot[1];
	end

	// Scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= slx_pkg::M_IDLE;
			op_q    <= '0;
			tline_q <= '0;
			tcol_q  <= '0;
			tlen_q  <= '0;
			kw_q    <= '0;
			line_q  <= '0;
			col_q   <= '0;
		end else if (fire) begin
			mode_q  <= mode_d;
			op_q    <= op_d;
			tline_q <= tline_d;
			tcol_q  <= tcol_d;
			tlen_q  <= tlen_d;
			kw_q    <= kw_d;
			line_q  <= line_d;
			col_q   <= col_d;
		end
	end

endmodule

// ===== rtl/core/slx_res_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slx_res_fifo
// Four-entry result queue: takes zero, one or two results per cycle from the
// scanner and presents one transaction at a time on the output channel.
// ----------------------------------------------------------------------------
module slx_res_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  slx_pkg::slx_res_t  res,
	output logic               room,
	output logic               out_valid,
	input  logic               out_ready,
	output slx_pkg::slx_out_t  out_item
);

	localparam int CW = slx_pkg::FIFO_AW + 1;

	slx_pkg::slx_out_t            mem [slx_pkg::FIFO_DEPTH];
	logic [slx_pkg::FIFO_AW-1:0]  wp_q, rp_q;
	logic [CW-1:0]                cnt_q;
	logic [1:0]                   push_n;
	logic                         pop;

	assign push_n    = push ? res.count : 2'd0;
	assign pop       = out_valid && out_ready;
	assign out_valid = (cnt_q != '0);
	assign out_item  = mem[rp_q];
	// room for the worst case of two results
	assign room      = (cnt_q <= CW'(slx_pkg::FIFO_DEPTH - 2));

	// Storage
	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem[wp_q] <= res.r0;
		if (push_n == 2'd2)
			mem[wp_q + slx_pkg::FIFO_AW'(1)] <= res.r1;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + slx_pkg::FIFO_AW'(push_n);
			if (pop)
				rp_q <= rp_q + slx_pkg::FIFO_AW'(1);
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

endmodule

// ===== rtl/core/script_lexer_byte_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_lexer_byte_stream
// Streaming tokenizer for a small scripting language: source bytes in,
// tokens with kind, position and length out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one source byte per transaction; end_of_source marks the last
//           byte, flushes the pending token and restarts at line 0.
//   out_* : one token or error per transaction; last_of_run marks the final
//           result caused by a given byte. A byte yields zero to two results.
//   Flow: a byte accepted into the input register is scanned once the
//   result queue has room; its results are then offered on out_valid.
//   Throughput: one byte per cycle unless stalled. The scanner state
//   update is a single registered pass; output is one result per cycle,
//   so runs of two-result bytes are limited by the four-entry queue draining.
//   Stall: when the receiver holds out_ready low the queue fills; the byte
//   in the input register waits, with in_ready low, until two slots are free.
//   Reset: arst_n clears the scanner state, the counters and the queue.
// ----------------------------------------------------------------------------
module script_lexer_byte_stream #(
	parameter int COUNTER_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  slx_pkg::slx_in_t  in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output slx_pkg::slx_out_t out_item
);

	slx_pkg::slx_in_t  item_s1;
	logic              vld_s1;
	logic              room;
	logic              fire;
	slx_pkg::slx_res_t res;

	// Scan the registered byte when the queue can take its results
	assign fire     = vld_s1 && room;
	assign in_ready = !vld_s1 || fire;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_item;
	end

	slx_scan #(
		.CB(COUNTER_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.res    (res)
	);

	slx_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.res       (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== rtl/core/slx_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slx_checker
// Port-level checks for the script lexer, bound to the top level.
// ----------------------------------------------------------------------------
module slx_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input slx_pkg::slx_out_t out_item
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// results start flowing after a byte transaction, through the input register and the queue
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a preceding byte");

	// error results carry kind zero
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.error_code != slx_pkg::ERR_NONE)
		|-> out_item.token_kind == slx_pkg::KIND_LEFT_PAREN)
		else $error("error result with nonzero kind");

	// unknown byte reports a one-byte lexeme
	a_bad_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.error_code == slx_pkg::ERR_BADCHAR)
		|-> out_item.lexeme_length == 16'd1)
		else $error("bad character length");

	// kind is in range and never the unused character kind
	a_kind_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.token_kind <= slx_pkg::KIND_NIL)
		&& (out_item.token_kind != slx_pkg::KIND_CHAR))
		else $error("token kind out of range");

endmodule

bind script_lexer_byte_stream slx_checker u_slx_checker (.*);

// ===== dv/tb_script_lexer_byte_stream.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_script_lexer_byte_stream
// Self-checking bench for the streaming script lexer. A queue of source bytes
// (directed cases and random token sequences) feeds a bursty driver; a local
// scanner model predicts the tokens of every accepted byte, and a monitor
// compares each token taken from the block, field by field, with the oldest
// one due.
// ----------------------------------------------------------------------------
module tb_script_lexer_byte_stream;

	localparam int RANDOM_ITEMS   = 2000;
	localparam int HOLD_AFTER     = 300;
	localparam int HOLD_CYCLES    = 600;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 16;

	// Error results carry kind zero
	localparam logic [5:0] ERR_KIND = slx_pkg::KIND_LEFT_PAREN;

	// Receiver stall patterns
	localparam logic [1:0] RX_FULL  = 2'd0;
	localparam logic [1:0] RX_HALF  = 2'd1;
	localparam logic [1:0] RX_SLOW  = 2'd2;
	localparam logic [1:0] RX_PULSE = 2'd3;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	slx_pkg::slx_in_t  in_item   = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	slx_pkg::slx_out_t out_item;

	script_lexer_byte_stream dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #2 clk = ~clk;

	slx_pkg::slx_in_t  src_q[$];
	slx_pkg::slx_out_t tokens_due[$];
	int                mismatches     = 0;
	int                tokens_checked = 0;

	string kw_words[16] = '{"and", "or", "class", "if", "else", "var", "func", "for",
		"while", "return", "print", "super", "this", "true", "false", "nil"};

	// ------------------------------------------------------------------
	// Scanner model state
	// ------------------------------------------------------------------
	logic [2:0]        lex_mode;
	logic [1:0]        op_pending;
	logic [15:0]       tok_line;
	logic [15:0]       tok_col;
	logic [15:0]       tok_len;
	logic [55:0]       kw_win;
	logic [15:0]       line_cnt;
	logic [15:0]       col_cnt;
	slx_pkg::slx_out_t step_res[2];
	int                step_n;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic is_numeral(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
	endfunction

	// Keyword lookup on the captured identifier prefix
	function automatic logic [5:0] word_kind();
		logic [5:0] k;
		logic       hit;
		k = slx_pkg::KIND_IDENTIFIER;
		for (int i = 0; i < 16; i++) begin
			if (int'(tok_len) == kw_words[i].len()) begin
				hit = 1'b1;
				for (int j = 0; j < kw_words[i].len(); j++)
					if (kw_win[8*j +: 8] != kw_words[i][j])
						hit = 1'b0;
				if (hit && k == slx_pkg::KIND_IDENTIFIER)
					k = slx_pkg::KIND_AND + 6'(i);
			end
		end
		return k;
	endfunction

	task automatic reset_lexer();
		lex_mode   = slx_pkg::M_IDLE;
		op_pending = slx_pkg::OP_BANG;
		tok_line   = '0;
		tok_col    = '0;
		tok_len    = '0;
		kw_win     = '0;
		line_cnt   = '0;
		col_cnt    = '0;
	endtask

	task automatic push_result(input logic [5:0] kind, input logic [1:0] err,
	                           input logic [15:0] ln, input logic [15:0] cl,
	                           input logic [15:0] len);
		if (step_n < 2) begin
			step_res[step_n].token_kind    = kind;
			step_res[step_n].error_code    = err;
			step_res[step_n].start_line    = ln;
			step_res[step_n].start_column  = cl;
			step_res[step_n].lexeme_length = len;
			step_res[step_n].last_of_run   = 1'b0;
			step_n++;
		end
	endtask

	task automatic start_token(input logic [2:0] mode, input logic [15:0] ln,
	                           input logic [15:0] cl);
		lex_mode = mode;
		tok_line = ln;
		tok_col  = cl;
		tok_len  = 16'd1;
	endtask

	// Scan a byte with nothing in progress
	task automatic scan_fresh(input logic [7:0] b, input logic [15:0] ln,
	                          input logic [15:0] cl);
		logic [5:0] k;
		logic       single;
		k        = slx_pkg::KIND_LEFT_PAREN;
		single   = 1'b1;
		lex_mode = slx_pkg::M_IDLE;
		case (b)
			slx_pkg::CH_LPAREN: k = slx_pkg::KIND_LEFT_PAREN;
			slx_pkg::CH_RPAREN: k = slx_pkg::KIND_RIGHT_PAREN;
			slx_pkg::CH_LBRACE: k = slx_pkg::KIND_LEFT_BRACE;
			slx_pkg::CH_RBRACE: k = slx_pkg::KIND_RIGHT_BRACE;
			slx_pkg::CH_COMMA:  k = slx_pkg::KIND_COMMA;
			slx_pkg::CH_DOT:    k = slx_pkg::KIND_DOT;
			slx_pkg::CH_MINUS:  k = slx_pkg::KIND_MINUS;
			slx_pkg::CH_PLUS:   k = slx_pkg::KIND_PLUS;
			slx_pkg::CH_SEMI:   k = slx_pkg::KIND_SEMICOLON;
			slx_pkg::CH_STAR:   k = slx_pkg::KIND_STAR;
			slx_pkg::CH_BANG: begin
				start_token(slx_pkg::M_OP, ln, cl);
				op_pending = slx_pkg::OP_BANG;
				single = 1'b0;
			end
			slx_pkg::CH_EQUAL: begin
				start_token(slx_pkg::M_OP, ln, cl);
				op_pending = slx_pkg::OP_EQUAL;
				single = 1'b0;
			end
			slx_pkg::CH_GREAT: begin
				start_token(slx_pkg::M_OP, ln, cl);
				op_pending = slx_pkg::OP_GREATER;
				single = 1'b0;
			end
			slx_pkg::CH_LESS: begin
				start_token(slx_pkg::M_OP, ln, cl);
				op_pending = slx_pkg::OP_LESS;
				single = 1'b0;
			end
			slx_pkg::CH_SLASH: begin
				start_token(slx_pkg::M_SLASH, ln, cl);
				single = 1'b0;
			end
			slx_pkg::CH_QUOTE: begin
				start_token(slx_pkg::M_STRING, ln, cl);
				single = 1'b0;
			end
			slx_pkg::CH_SP, slx_pkg::CH_CR, slx_pkg::CH_TAB, slx_pkg::CH_NL: single = 1'b0;
			default: begin
				single = 1'b0;
				if (is_numeral(b)) begin
					start_token(slx_pkg::M_INT, ln, cl);
				end else if (is_letter(b)) begin
					start_token(slx_pkg::M_IDENT, ln, cl);
					kw_win = {48'b0, b};
				end else begin
					push_result(ERR_KIND, slx_pkg::ERR_BADCHAR, ln, cl, 16'd1);
				end
			end
		endcase
		if (single)
			push_result(k, slx_pkg::ERR_NONE, ln, cl, 16'd1);
	endtask

	// Predict the tokens of one accepted byte and queue them
	task automatic lex_byte(input slx_pkg::slx_in_t it);
		logic [7:0]  b;
		logic [15:0] ln;
		logic [15:0] cl;
		b      = it.source_byte;
		ln     = line_cnt;
		cl     = sat_inc(col_cnt);
		step_n = 0;
		case (lex_mode)
			slx_pkg::M_OP: begin
				if (b == slx_pkg::CH_EQUAL) begin
					push_result(slx_pkg::KIND_BANG_EQ + 6'(2 * op_pending), slx_pkg::ERR_NONE,
						tok_line, tok_col, 16'd2);
					lex_mode = slx_pkg::M_IDLE;
				end else begin
					push_result(slx_pkg::KIND_BANG + 6'(2 * op_pending), slx_pkg::ERR_NONE,
						tok_line, tok_col, 16'd1);
					scan_fresh(b, ln, cl);
				end
			end
			slx_pkg::M_SLASH: begin
				if (b == slx_pkg::CH_SLASH) begin
					lex_mode = slx_pkg::M_COMMENT;
					tok_len = 16'd2;
				end else begin
					push_result(slx_pkg::KIND_SLASH, slx_pkg::ERR_NONE, tok_line, tok_col,
						16'd1);
					scan_fresh(b, ln, cl);
				end
			end
			slx_pkg::M_COMMENT: begin
				if (b == slx_pkg::CH_NL) begin
					push_result(slx_pkg::KIND_COMMENT, slx_pkg::ERR_NONE, tok_line, tok_col,
						tok_len);
					lex_mode = slx_pkg::M_IDLE;
				end else begin
					tok_len = sat_inc(tok_len);
				end
			end
			slx_pkg::M_STRING: begin
				tok_len = sat_inc(tok_len);
				if (b == slx_pkg::CH_QUOTE) begin
					push_result(slx_pkg::KIND_STRING, slx_pkg::ERR_NONE, tok_line, tok_col,
						tok_len);
					lex_mode = slx_pkg::M_IDLE;
				end
			end
			slx_pkg::M_INT: begin
				if (is_numeral(b) || b == slx_pkg::CH_UNDER) begin
					tok_len = sat_inc(tok_len);
				end else if (b == slx_pkg::CH_DOT) begin
					tok_len = sat_inc(tok_len);
					lex_mode = slx_pkg::M_FRAC;
				end else begin
					push_result(slx_pkg::KIND_NUMBER, slx_pkg::ERR_NONE, tok_line, tok_col,
						tok_len);
					scan_fresh(b, ln, cl);
				end
			end
			slx_pkg::M_FRAC: begin
				if (is_numeral(b)) begin
					tok_len = sat_inc(tok_len);
				end else begin
					push_result(slx_pkg::KIND_NUMBER, slx_pkg::ERR_NONE, tok_line, tok_col,
						tok_len);
					scan_fresh(b, ln, cl);
				end
			end
			slx_pkg::M_IDENT: begin
				if (is_letter(b) || is_numeral(b)) begin
					if (tok_len < 16'd7)
						kw_win[8*tok_len[2:0] +: 8] = b;
					tok_len = sat_inc(tok_len);
				end else begin
					push_result(word_kind(), slx_pkg::ERR_NONE, tok_line, tok_col, tok_len);
					scan_fresh(b, ln, cl);
				end
			end
			default: scan_fresh(b, ln, cl);
		endcase

		if (b == slx_pkg::CH_NL) begin
			line_cnt = sat_inc(ln);
			col_cnt  = '0;
		end else begin
			col_cnt = cl;
		end

		// End of source: flush what is pending, then start over
		if (it.end_of_source) begin
			case (lex_mode)
				slx_pkg::M_OP: push_result(slx_pkg::KIND_BANG + 6'(2 * op_pending),
					slx_pkg::ERR_NONE, tok_line, tok_col, 16'd1);
				slx_pkg::M_SLASH: push_result(slx_pkg::KIND_SLASH, slx_pkg::ERR_NONE,
					tok_line, tok_col, 16'd1);
				slx_pkg::M_COMMENT: push_result(slx_pkg::KIND_COMMENT, slx_pkg::ERR_NONE,
					tok_line, tok_col, tok_len);
				slx_pkg::M_STRING: push_result(ERR_KIND, slx_pkg::ERR_UNTERM,
					tok_line, tok_col, tok_len);
				slx_pkg::M_INT, slx_pkg::M_FRAC: push_result(slx_pkg::KIND_NUMBER,
					slx_pkg::ERR_NONE, tok_line, tok_col, tok_len);
				slx_pkg::M_IDENT: push_result(word_kind(), slx_pkg::ERR_NONE,
					tok_line, tok_col, tok_len);
				default: ;
			endcase
			reset_lexer();
		end

		if (step_n > 0)
			step_res[step_n-1].last_of_run = 1'b1;
		for (int i = 0; i < step_n; i++)
			tokens_due.push_back(step_res[i]);
	endtask

	// ------------------------------------------------------------------
	// Source text generation
	// ------------------------------------------------------------------
	task automatic push_byte(input logic [7:0] b);
		slx_pkg::slx_in_t t;
		t.source_byte   = b;
		t.end_of_source = 1'b0;
		src_q.push_back(t);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	// Mark the most recent byte as the end of the source
	task automatic mark_end();
		slx_pkg::slx_in_t t;
		t = src_q.pop_back();
		t.end_of_source = 1'b1;
		src_q.push_back(t);
	endtask

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(0, 1))
			return 8'("a" + $urandom_range(0, 25));
		return 8'("A" + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] rand_space();
		case ($urandom_range(0, 3))
			0: return slx_pkg::CH_SP;
			1: return slx_pkg::CH_TAB;
			2: return slx_pkg::CH_CR;
			default: return slx_pkg::CH_NL;
		endcase
	endfunction

	// One well-formed token (mostly) with random content, often followed by a separator
	task automatic push_snippet();
		logic [7:0] b;
		logic [7:0] punct[11];
		logic [7:0] opers[4];
		int         n;
		punct = '{slx_pkg::CH_LPAREN, slx_pkg::CH_RPAREN, slx_pkg::CH_LBRACE,
			slx_pkg::CH_RBRACE, slx_pkg::CH_COMMA, slx_pkg::CH_DOT, slx_pkg::CH_MINUS,
			slx_pkg::CH_PLUS, slx_pkg::CH_SEMI, slx_pkg::CH_STAR, slx_pkg::CH_SLASH};
		opers = '{slx_pkg::CH_BANG, slx_pkg::CH_EQUAL, slx_pkg::CH_GREAT, slx_pkg::CH_LESS};
		case ($urandom_range(0, 9))
			0, 1: begin
				// identifier or keyword
				if ($urandom_range(0, 2) == 0) begin
					push_text(kw_words[$urandom_range(0, 15)]);
					if ($urandom_range(0, 4) == 0)
						push_byte($urandom_range(0, 1) ? rand_letter() : 8'("0" + $urandom_range(0, 9)));
				end else begin
					push_byte(rand_letter());
					n = $urandom_range(0, 9);
					for (int i = 0; i < n; i++)
						push_byte($urandom_range(0, 2) ? rand_letter() : 8'("0" + $urandom_range(0, 9)));
				end
			end
			2: begin
				// number with separators and optional fraction
				push_byte(8'("0" + $urandom_range(0, 9)));
				n = $urandom_range(0, 5);
				for (int i = 0; i < n; i++)
					push_byte($urandom_range(0, 3) ? 8'("0" + $urandom_range(0, 9))
						: slx_pkg::CH_UNDER);
				if ($urandom_range(0, 1)) begin
					push_byte(slx_pkg::CH_DOT);
					n = $urandom_range(0, 3);
					for (int i = 0; i < n; i++)
						push_byte(8'("0" + $urandom_range(0, 9)));
				end
			end
			3: begin
				// string, now and then left open at end of source
				push_byte(slx_pkg::CH_QUOTE);
				n = $urandom_range(0, 8);
				for (int i = 0; i < n; i++) begin
					b = 8'($urandom_range(0, 255));
					if (b == slx_pkg::CH_QUOTE)
						b = slx_pkg::CH_NL;
					push_byte(b);
				end
				if ($urandom_range(0, 9) == 0)
					mark_end();
				else
					push_byte(slx_pkg::CH_QUOTE);
			end
			4: begin
				// line comment
				push_text("//");
				n = $urandom_range(0, 10);
				for (int i = 0; i < n; i++) begin
					b = 8'($urandom_range(0, 255));
					if (b == slx_pkg::CH_NL)
						b = slx_pkg::CH_SP;
					push_byte(b);
				end
				if ($urandom_range(0, 9) == 0)
					mark_end();
				else
					push_byte(slx_pkg::CH_NL);
			end
			5: begin
				push_byte(opers[$urandom_range(0, 3)]);
				if ($urandom_range(0, 1))
					push_byte(slx_pkg::CH_EQUAL);
			end
			6, 7: push_byte(punct[$urandom_range(0, 10)]);
			8: push_byte(8'($urandom_range(0, 255)));
			default: push_byte(rand_space());
		endcase
		if ($urandom_range(0, 4) >= 2)
			push_byte(rand_space());
		if ($urandom_range(0, 39) == 0)
			mark_end();
	endtask

	// ------------------------------------------------------------------
	// Driver: bursts of transactions with random gaps
	// ------------------------------------------------------------------
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_item    <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (in_valid && in_ready)
				lex_byte(in_item);
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (src_q.size() != 0) begin
					in_item  <= src_q.pop_front();
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 48);
						gap_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
							: $urandom_range(0, 4);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: changing stall patterns plus one long hold-off
	// ------------------------------------------------------------------
	logic [1:0] rx_mode;
	int         rx_left;
	int         hold_left;
	logic       hold_done;
	int         rx_taken;
	logic [7:0] rx_tick;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_mode   <= RX_FULL;
			rx_left   <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
			rx_taken  <= 0;
			rx_tick   <= '0;
		end else begin
			rx_tick <= rx_tick + 8'd1;
			if (out_valid && out_ready)
				rx_taken <= rx_taken + 1;
			if (!hold_done && rx_taken >= HOLD_AFTER) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode <= 2'($urandom_range(0, 3));
					rx_left <= $urandom_range(32, 400);
				end else begin
					rx_left <= rx_left - 1;
				end
				case (rx_mode)
					RX_FULL:  out_ready <= 1'b1;
					RX_HALF:  out_ready <= 1'($urandom_range(0, 1));
					RX_SLOW:  out_ready <= ($urandom_range(0, 4) == 0);
					default:  out_ready <= rx_tick[2];
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor and checks
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("MISMATCH @%0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("token %0d %s: got %0d, expected %0d",
				tokens_checked, name, got, want));
	endtask

	always @(posedge clk) begin
		slx_pkg::slx_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (tokens_due.size() == 0) begin
				report_mismatch($sformatf("unexpected token kind %0d at line %0d column %0d",
					out_item.token_kind, out_item.start_line, out_item.start_column));
			end else begin
				want = tokens_due.pop_front();
				check_field("token_kind", out_item.token_kind, want.token_kind);
				check_field("error_code", out_item.error_code, want.error_code);
				check_field("start_line", out_item.start_line, want.start_line);
				check_field("start_column", out_item.start_column, want.start_column);
				check_field("lexeme_length", out_item.lexeme_length, want.lexeme_length);
				check_field("last_of_run", out_item.last_of_run, want.last_of_run);
			end
			tokens_checked++;
		end
	end

	// Watchdog: no transaction on either side for too long
	int stall_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int base;
		reset_lexer();

		// Directed: all punctuation, operator pairs and lookahead, a comment,
		// byte extremes, a trailing fraction dot and an open string at the end
		push_text("(){},.-+;*");
		push_text("!=<>=");
		push_text("//c\n");
		push_byte(8'hFF);
		push_byte(8'h00);
		push_text("9.");
		mark_end();
		push_text("\"s");
		mark_end();

		base = src_q.size();
		while (src_q.size() < base + RANDOM_ITEMS)
			push_snippet();
		mark_end();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (src_q.size() != 0 || in_valid || tokens_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/slx_pkg.sv
rtl/core/slx_scan.sv
rtl/core/slx_res_fifo.sv
rtl/core/script_lexer_byte_stream.sv
rtl/core/slx_checker.sv
dv/tb_script_lexer_byte_stream.sv
